[hw/rtl/indexed_ordered_list_engine_core_assert.svh]
// assertion macros used by the iole_dp rtl file
// both expect clk_i and rst_ni in the enclosing module
`ifndef INDEXED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define INDEXED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define IOLE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iole assertion failed");

// next-cycle implication
`define IOLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iole assertion failed");

`endif

[hw/rtl/iole_pkg.sv]
package iole_pkg;

  typedef enum logic [2:0] {
    FUNC_APPEND   = 3'd0,
    FUNC_INSERT   = 3'd1,
    FUNC_DELETE   = 3'd2,
    FUNC_GET      = 3'd3,
    FUNC_DEL_HEAD = 3'd4,
    FUNC_CLEAR    = 3'd5
  } iole_func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SHIFT,
    ST_DRAIN,
    ST_PLACE,
    ST_GET_RD,
    ST_GET_WAIT,
    ST_FINISH
  } iole_state_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load;
    logic init_up;
    logic init_dn;
    logic init_get;
    logic rd_en;
    logic shift;
    logic place;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic set_refused;
    logic cap;
    logic finish;
  } iole_cmd_t;

  // datapath to controller
  typedef struct packed {
    iole_func_e func;
    logic       full;
    logic       hit;
    logic       shift_up;
    logic       shift_dn;
    logic       last;
    logic       out_free;
  } iole_sts_t;

endpackage

[hw/rtl/iole_if.sv]
interface iole_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [5:0]  position;
  logic [31:0] entry_data;

  modport source (output valid, output func, output position, output entry_data, input ready);
  modport sink (input valid, input func, input position, input entry_data, output ready);
endinterface

interface iole_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        found;
  logic        refused;
  logic [6:0]  list_length;

  modport source (output valid, output read_data, output found, output refused,
                  output list_length, input ready);
  modport sink (input valid, input read_data, input found, input refused,
                input list_length, output ready);
endinterface

[hw/rtl/iole_ctrl.sv]
module iole_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  iole_pkg::iole_sts_t sts_i,
  output iole_pkg::iole_cmd_t cmd_o
);

  iole_pkg::iole_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iole_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iole_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = iole_pkg::ST_DECIDE;
      end
      iole_pkg::ST_DECIDE: begin
        case (sts_i.func)
          iole_pkg::FUNC_APPEND, iole_pkg::FUNC_INSERT: begin
            if (sts_i.full) state_d = iole_pkg::ST_FINISH;
            else if (sts_i.shift_up) state_d = iole_pkg::ST_SHIFT;
            else state_d = iole_pkg::ST_PLACE;
          end
          iole_pkg::FUNC_DELETE, iole_pkg::FUNC_DEL_HEAD: begin
            if (sts_i.hit && sts_i.shift_dn) state_d = iole_pkg::ST_SHIFT;
            else state_d = iole_pkg::ST_FINISH;
          end
          iole_pkg::FUNC_GET: begin
            if (sts_i.hit) state_d = iole_pkg::ST_GET_RD;
            else state_d = iole_pkg::ST_FINISH;
          end
          default: state_d = iole_pkg::ST_FINISH;
        endcase
      end
      iole_pkg::ST_SHIFT: begin
        if (sts_i.last) state_d = iole_pkg::ST_DRAIN;
      end
      iole_pkg::ST_DRAIN: begin
        if (sts_i.func == iole_pkg::FUNC_INSERT || sts_i.func == iole_pkg::FUNC_APPEND) begin
          state_d = iole_pkg::ST_PLACE;
        end else begin
          state_d = iole_pkg::ST_FINISH;
        end
      end
      iole_pkg::ST_PLACE:    state_d = iole_pkg::ST_FINISH;
      iole_pkg::ST_GET_RD:   state_d = iole_pkg::ST_GET_WAIT;
      iole_pkg::ST_GET_WAIT: state_d = iole_pkg::ST_FINISH;
      iole_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = iole_pkg::ST_IDLE;
      end
      default: state_d = iole_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      iole_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = in_valid_i;
      end
      iole_pkg::ST_DECIDE: begin
        case (sts_i.func)
          iole_pkg::FUNC_APPEND, iole_pkg::FUNC_INSERT: begin
            if (sts_i.full) cmd_o.set_refused = 1'b1;
            else if (sts_i.shift_up) cmd_o.init_up = 1'b1;
          end
          iole_pkg::FUNC_DELETE, iole_pkg::FUNC_DEL_HEAD: begin
            if (sts_i.hit) begin
              if (sts_i.shift_dn) cmd_o.init_dn = 1'b1;
              else cmd_o.cnt_dec = 1'b1;
            end
          end
          iole_pkg::FUNC_GET: begin
            if (sts_i.hit) cmd_o.init_get = 1'b1;
          end
          iole_pkg::FUNC_CLEAR: cmd_o.cnt_clr = 1'b1;
          default: ;
        endcase
      end
      iole_pkg::ST_SHIFT: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.shift = 1'b1;
      end
      iole_pkg::ST_DRAIN: begin
        if (sts_i.func != iole_pkg::FUNC_INSERT && sts_i.func != iole_pkg::FUNC_APPEND) begin
          cmd_o.cnt_dec = 1'b1;
        end
      end
      iole_pkg::ST_PLACE: begin
        cmd_o.place   = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      iole_pkg::ST_GET_RD:   cmd_o.rd_en  = 1'b1;
      iole_pkg::ST_GET_WAIT: cmd_o.cap    = 1'b1;
      iole_pkg::ST_FINISH:   cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

[hw/rtl/iole_dp.sv]
`include "indexed_ordered_list_engine_core_assert.svh"

module iole_dp #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iole_pkg::iole_cmd_t cmd_i,
  output iole_pkg::iole_sts_t sts_o,
  input  logic [2:0]          func_i,
  input  logic [5:0]          position_i,
  input  logic [31:0]         entry_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [31:0]         read_data_o,
  output logic                found_o,
  output logic                refused_o,
  output logic [6:0]          list_length_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 6) ? CW : 6;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  iole_pkg::iole_func_e  func_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic [AW-1:0]         tgt_q;
  logic                  hit_q;
  logic [CW-1:0]         count_q;
  logic [AW-1:0]         ptr_q;
  logic                  dir_up_q;
  logic                  wr_pend_q;
  logic [AW-1:0]         wr_addr_q;
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic [DATA_WIDTH-1:0] res_data_q;
  logic                  found_q;
  logic                  refused_q;
  logic                  out_valid_q;
  logic [31:0]           out_data_q;
  logic                  out_found_q;
  logic                  out_refused_q;
  logic [6:0]            out_len_q;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic          below;
  logic [AW-1:0] tgt_d;
  logic [AW-1:0] cnt_m1;
  logic          out_free;
  iole_pkg::iole_func_e func_in;

  assign func_in  = iole_pkg::iole_func_e'(func_i);
  assign pos_w    = PW'(position_i);
  assign cnt_w    = PW'(count_q);
  assign below    = pos_w < cnt_w;
  assign cnt_m1   = AW'(count_q - CW'(1));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (func_in == iole_pkg::FUNC_DEL_HEAD) tgt_d = '0;
    else if (func_in != iole_pkg::FUNC_APPEND && below) tgt_d = pos_w[AW-1:0];
    else tgt_d = count_q[AW-1:0];
  end

  assign sts_o.func     = func_q;
  assign sts_o.full     = count_q == CW'(DEPTH);
  assign sts_o.hit      = hit_q;
  assign sts_o.shift_up = CW'(tgt_q) < count_q;
  assign sts_o.shift_dn = (CW'(tgt_q) + CW'(1)) < count_q;
  assign sts_o.last     = dir_up_q ? (ptr_q == tgt_q) : (ptr_q == cnt_m1);
  assign sts_o.out_free = out_free;

  // request and result payload, shift pointer, direction and write address
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_in;
      word_q <= DATA_WIDTH'(entry_data_i);
      tgt_q  <= tgt_d;
      hit_q  <= (func_in == iole_pkg::FUNC_DEL_HEAD) ? (count_q != '0) : below;
    end
    if (cmd_i.init_up) ptr_q <= cnt_m1;
    else if (cmd_i.init_dn) ptr_q <= tgt_q + AW'(1);
    else if (cmd_i.init_get) ptr_q <= tgt_q;
    else if (cmd_i.shift) ptr_q <= dir_up_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
    if (cmd_i.init_up) dir_up_q <= 1'b1;
    else if (cmd_i.init_dn) dir_up_q <= 1'b0;
    if (cmd_i.shift) wr_addr_q <= dir_up_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
    if (cmd_i.load) res_data_q <= '0;
    else if (cmd_i.cap) res_data_q <= rd_data_q;
    if (cmd_i.finish && out_free) begin
      out_data_q    <= 32'(res_data_q);
      out_found_q   <= found_q;
      out_refused_q <= refused_q;
      out_len_q     <= 7'(count_q);
    end
  end

  // list storage, one write and one read port
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) mem[wr_addr_q] <= rd_data_q;
    else if (cmd_i.place) mem[tgt_q] <= word_q;
    if (cmd_i.rd_en) rd_data_q <= mem[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wr_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      refused_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.shift;
      if (cmd_i.cnt_clr) count_q <= '0;
      else if (cmd_i.cnt_inc) count_q <= count_q + CW'(1);
      else if (cmd_i.cnt_dec) count_q <= count_q - CW'(1);
      if (cmd_i.load) begin
        found_q   <= 1'b0;
        refused_q <= 1'b0;
      end else begin
        if (cmd_i.cap) found_q <= 1'b1;
        if (cmd_i.set_refused) refused_q <= 1'b1;
      end
      if (cmd_i.finish && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_data_q;
  assign found_o       = out_found_q;
  assign refused_o     = out_refused_q;
  assign list_length_o = out_len_q;

  `IOLE_ASSERT_IMPL(a_count_max, 1'b1, count_q <= CW'(DEPTH))
  `IOLE_ASSERT_IMPL(a_wr_port, wr_pend_q, !cmd_i.place)
  `IOLE_ASSERT_NEXT(a_refused_full, cmd_i.set_refused, refused_q && count_q == CW'(DEPTH))

endmodule

[hw/rtl/indexed_ordered_list_engine_core.sv]
// sequence: a miss, refusal, clear, no-op or tail removal goes from decode to the result; a get
//   hit adds a read and a capture step, append or insert a place step; moving entries adds a
//   shift pass and a drain step first; one item at a time, one entry moved per cycle, and
//   the next word is accepted the cycle after the result enters the output register
// reset: asynchronous, active low; clears the entry count and all handshake state,
//   list memory is left as is and needs no clearing pass
module indexed_ordered_list_engine_core #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  iole_req_if.sink   req_i,
  iole_rsp_if.source rsp_o
);

  // command and status between sequencer and datapath
  iole_pkg::iole_cmd_t cmd;
  iole_pkg::iole_sts_t sts;

  // request word taken only while the sequencer sits idle
  assign req_i.ready = cmd.in_ready;

  // sequencer: decides shift direction, place, read and count updates
  iole_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: list memory, pointers, count and the result register
  iole_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (req_i.func),
    .position_i    (req_i.position),
    .entry_data_i  (req_i.entry_data),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .read_data_o   (rsp_o.read_data),
    .found_o       (rsp_o.found),
    .refused_o     (rsp_o.refused),
    .list_length_o (rsp_o.list_length)
  );

endmodule
